@@ rtl/kmm_pkg.sv @@
package kmm_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_NOTE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_VELOCITY  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDI_CHANNEL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESSED_CODE = 2'd3;

  // Reset values of the registers
  localparam logic [6:0] BASE_NOTE_RST    = 7'd24;
  localparam logic [6:0] ON_VELOCITY_RST  = 7'd120;
  localparam logic [3:0] MIDI_CHANNEL_RST = 4'd0;
  localparam logic [7:0] PRESSED_CODE_RST = 8'haa;

  // USB-MIDI code index and status nibbles
  localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
  localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  localparam logic [7:0] NOTE_MAX = 8'd127;

  // Command codes carried in tuser
  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_REMOTE = 1'b1;

  typedef struct packed {
    logic       down;
    logic [6:0] note;
    logic [5:0] key;
    logic [2:0] col;
  } kmm_event_t;

  typedef struct packed {
    logic [2:0] col;
    logic [5:0] key;
    logic [6:0] velocity;
    logic [6:0] note;
    logic [7:0] status;
    logic [3:0] cable;
  } kmm_result_t;

  // Major-scale step within an octave
  function automatic logic [3:0] scale_step(input int unsigned s);
    logic [3:0] v;
    unique case (s)
      0:       v = 4'd0;
      1:       v = 4'd2;
      2:       v = 4'd4;
      3:       v = 4'd5;
      4:       v = 4'd7;
      default: v = 4'd9;
    endcase
    return v;
  endfunction

  // Semitone offset of a column: octaves of six columns plus the scale step
  function automatic logic [5:0] col_offset(input logic [3:0] c);
    logic [5:0] v;
    if (c < 4'd6) begin
      v = 6'(scale_step(32'(c)));
    end else if (c < 4'd12) begin
      v = 6'd12 + 6'(scale_step(32'(c - 4'd6)));
    end else begin
      v = 6'd24 + 6'(scale_step(32'(c - 4'd12)));
    end
    return v;
  endfunction

endpackage

@@ rtl/kmm_lane.sv @@
module kmm_lane #(
  parameter int ROW        = 0,
  parameter int COLUMNS    = 6,
  parameter int LOCAL_KEYS = 24,
  parameter int CW         = 3,
  parameter int KW         = 5,
  parameter int IW         = 6
) (
  input  logic [CW-1:0]         col,
  input  logic                  level,
  input  logic [LOCAL_KEYS-1:0] key_state,
  input  logic [6:0]            base_note,
  output logic                  change,
  output logic [KW-1:0]         key_idx,
  output kmm_pkg::kmm_event_t   ev
);
  import kmm_pkg::*;

  logic [IW-1:0] idx;
  logic          in_matrix;
  logic          down;
  logic [7:0]    note_sum;

  assign idx       = IW'(ROW * COLUMNS) + IW'(col);
  assign in_matrix = idx < IW'(LOCAL_KEYS);
  assign key_idx   = idx[KW-1:0];
  assign down      = ~level;
  assign change    = in_matrix && (key_state[key_idx] != down);

  // base + 12 per row + column offset, clamped
  assign note_sum = 8'(base_note) + 8'(12 * ROW) + 8'(col_offset(4'(col)));

  always_comb begin
    ev.down = down;
    ev.note = (note_sum > NOTE_MAX) ? NOTE_MAX[6:0] : note_sum[6:0];
    ev.key  = 6'(idx);
    ev.col  = 3'(col);
  end

endmodule

@@ rtl/kmm_merge.sv @@
module kmm_merge #(
  parameter int NL = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [NL-1:0]       lane_mask,
  input  kmm_pkg::kmm_event_t lane_ev [NL],
  input  logic [6:0]          on_velocity,
  input  logic [3:0]          midi_channel,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output kmm_pkg::kmm_result_t out_res,
  output logic                out_last
);
  import kmm_pkg::*;

  logic [NL-1:0] pend_mask_r, pend_mask_nxt;
  kmm_event_t    pend_ev_r [NL];
  logic          out_valid_r, out_valid_nxt;
  kmm_result_t   out_res_r;
  logic          out_last_r;

  logic [NL-1:0] pick_oh, rest, mask_left;
  logic          found, out_free, move;
  kmm_event_t    pick_ev;

  // Pick the lowest pending lane
  always_comb begin
    pick_oh = '0;
    found   = 1'b0;
    pick_ev = pend_ev_r[0];
    for (int i = 0; i < NL; i++) begin
      if (pend_mask_r[i] && !found) begin
        pick_oh[i] = 1'b1;
        found      = 1'b1;
        pick_ev    = pend_ev_r[i];
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign move      = found && out_free;
  assign rest      = pend_mask_r & ~pick_oh;
  assign mask_left = move ? rest : pend_mask_r;
  assign in_ready  = (mask_left == '0);

  assign pend_mask_nxt = load ? lane_mask : mask_left;
  assign out_valid_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_mask_r <= pend_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NL; i++) begin
        pend_ev_r[i] <= lane_ev[i];
      end
    end
    if (move) begin
      out_res_r.cable    <= pick_ev.down ? CIN_NOTE_ON : CIN_NOTE_OFF;
      out_res_r.status   <= {(pick_ev.down ? STATUS_NOTE_ON : STATUS_NOTE_OFF), midi_channel};
      out_res_r.note     <= pick_ev.note;
      out_res_r.velocity <= pick_ev.down ? on_velocity : 7'd0;
      out_res_r.key      <= pick_ev.key;
      out_res_r.col      <= pick_ev.col;
      out_last_r         <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/key_matrix_to_midi_events.sv @@
// Key matrix scanner producing USB-MIDI note events.
// Input channel (in_*): one request per item. tuser is the command: scan
// selects a local column scan of the row levels, remote carries one key byte
// of the other keyboard half. The column under scan advances on scan items.
// Output channel (out_*): one request per note event, tlast on the final
// event of the item that caused it; an item that changes no key gives none.
// Configuration (cfg_*): write base note, velocity, channel and pressed code
// while the block is idle; writes take effect at once.
// The first event of an item passes the merge stage and the output register.
// Throughput: the row lanes compare all rows of a column at once; the
// merge stage then sends the changes one per cycle while the output register
// is free, and in_tready returns once the last pending event has moved on.
// A scan item gives up to four events when four rows change at once.
// Reset clears every key to released, the column counter to zero and the
// registers to their defaults. While the receiver stalls the held event
// waits in the output register; the pending events wait in the merge stage
// and in_tready falls until they have been moved on.
module key_matrix_to_midi_events #(
  parameter int LOCAL_KEYS  = 24,
  parameter int REMOTE_KEYS = 27,
  parameter int COLUMNS     = 6,
  parameter int ROWS        = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // row_levels[3:0], remote_index[8:4], remote_byte[16:9], zero fill
  input  logic [kmm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cable_code[3:0], status_byte[11:4], note_number[18:12],
  // velocity_out[25:19], key_number[31:26], scan_column[34:32], zero fill
  output logic [kmm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // event_valid
  output logic                             out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [kmm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kmm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kmm_pkg::*;

  localparam int TOTAL = LOCAL_KEYS + REMOTE_KEYS;
  localparam int NL    = (ROWS < 4) ? ROWS : 4;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int KW    = $clog2(TOTAL);
  localparam int LKW   = $clog2(LOCAL_KEYS);
  localparam int LIW   = $clog2(NL * COLUMNS + 1);
  localparam int IW    = (LIW > KW) ? LIW : KW;

  // Configuration registers
  logic [6:0] base_note_r, on_velocity_r;
  logic [3:0] midi_channel_r;
  logic [7:0] pressed_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_note_r    <= BASE_NOTE_RST;
      on_velocity_r  <= ON_VELOCITY_RST;
      midi_channel_r <= MIDI_CHANNEL_RST;
      pressed_code_r <= PRESSED_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE_NOTE:    base_note_r    <= cfg_wdata[6:0];
        REG_ON_VELOCITY:  on_velocity_r  <= cfg_wdata[6:0];
        REG_MIDI_CHANNEL: midi_channel_r <= cfg_wdata[3:0];
        REG_PRESSED_CODE: pressed_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields
  logic       command;
  logic [3:0] row_levels;
  logic [4:0] remote_index;
  logic [7:0] remote_byte;
  logic       in_accept;

  assign command      = in_tuser;
  assign row_levels   = in_tdata[3:0];
  assign remote_index = in_tdata[8:4];
  assign remote_byte  = in_tdata[16:9];
  assign in_accept    = in_tvalid && in_tready;

  // Key state, local matrix and remote half kept apart, and column counter
  logic [LOCAL_KEYS-1:0]  loc_key_r, loc_key_nxt;
  logic [REMOTE_KEYS-1:0] rem_key_r, rem_key_nxt;
  logic [CW-1:0]          col_r, col_nxt;

  // Row lanes: one per scanned row
  logic           lane_change [NL];
  logic [LKW-1:0] lane_key [NL];
  kmm_event_t     lane_ev [NL];

  for (genvar r = 0; r < NL; r++) begin : g_lane
    kmm_lane #(
      .ROW        (r),
      .COLUMNS    (COLUMNS),
      .LOCAL_KEYS (LOCAL_KEYS),
      .CW         (CW),
      .KW         (LKW),
      .IW         (IW)
    ) u_lane (
      .col       (col_r),
      .level     (row_levels[r]),
      .key_state (loc_key_r),
      .base_note (base_note_r),
      .change    (lane_change[r]),
      .key_idx   (lane_key[r]),
      .ev        (lane_ev[r])
    );
  end

  // Remote note offsets, one per remote index value, worked out at elaboration
  logic [9:0] rem_off [32];
  for (genvar i = 0; i < 32; i++) begin : g_rem_off
    localparam int LCOL = i % COLUMNS;
    localparam int OFF  = (i < LOCAL_KEYS)
                          ? 12 * (i / COLUMNS) + 12 * (LCOL / 6) + int'(scale_step(LCOL % 6))
                          : 36 + int'(scale_step(3 + ((i - LOCAL_KEYS) % 3)));
    assign rem_off[i] = 10'(OFF);
  end

  // Remote key
  logic          rem_in_range, rem_down, rem_change;
  logic [10:0]   rem_sum;
  kmm_event_t    rem_ev;

  assign rem_in_range = remote_index < 5'(REMOTE_KEYS);
  assign rem_down     = (remote_byte == pressed_code_r);
  assign rem_change   = rem_in_range && (rem_key_r[remote_index] != rem_down);
  assign rem_sum      = 11'(base_note_r) + 11'(rem_off[remote_index]);

  always_comb begin
    rem_ev.down = rem_down;
    rem_ev.note = (rem_sum > 11'(NOTE_MAX)) ? NOTE_MAX[6:0] : rem_sum[6:0];
    rem_ev.key  = 6'(LOCAL_KEYS + 32'(remote_index));
    rem_ev.col  = 3'd0;
  end

  // Lane results into the merge stage; a remote event takes lane zero
  logic [NL-1:0] load_mask;
  kmm_event_t    load_ev [NL];

  always_comb begin
    for (int r = 0; r < NL; r++) begin
      load_mask[r] = (command == CMD_SCAN) && lane_change[r];
      load_ev[r]   = lane_ev[r];
    end
    if (command == CMD_REMOTE) begin
      load_mask[0] = rem_change;
      load_ev[0]   = rem_ev;
    end
  end

  // Update the stored key levels and advance the column on a scan
  always_comb begin
    loc_key_nxt = loc_key_r;
    rem_key_nxt = rem_key_r;
    col_nxt     = col_r;
    if (in_accept) begin
      if (command == CMD_SCAN) begin
        for (int r = 0; r < NL; r++) begin
          if (lane_change[r]) begin
            loc_key_nxt[lane_key[r]] = lane_ev[r].down;
          end
        end
        col_nxt = (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
      end else if (rem_change) begin
        rem_key_nxt[remote_index] = rem_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_key_r <= '0;
      rem_key_r <= '0;
      col_r     <= '0;
    end else begin
      loc_key_r <= loc_key_nxt;
      rem_key_r <= rem_key_nxt;
      col_r     <= col_nxt;
    end
  end

  // Merge stage and output register
  kmm_result_t out_res;

  kmm_merge #(
    .NL (NL)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_accept),
    .lane_mask    (load_mask),
    .lane_ev      (load_ev),
    .on_velocity  (on_velocity_r),
    .midi_channel (midi_channel_r),
    .in_ready     (in_tready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (out_res),
    .out_last     (out_tlast)
  );

  assign out_tdata = {5'd0, out_res.col, out_res.key, out_res.velocity,
                      out_res.note, out_res.status, out_res.cable};
  assign out_tuser = 1'b1;

endmodule

@@ tb/sv/kmm_event_checker.sv @@
module kmm_event_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [kmm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kmm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            out_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [kmm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kmm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import kmm_pkg::*;

  localparam int NUM_LOCAL  = 24;
  localparam int NUM_REMOTE = 27;
  localparam int NUM_COLS   = 6;
  localparam int NUM_KEYS   = NUM_LOCAL + NUM_REMOTE;

  typedef struct {
    kmm_result_t f;
    logic        last;
  } midi_event_t;

  logic        key_down [NUM_KEYS];
  logic [2:0]  scan_col;
  logic [6:0]  base_note;
  logic [6:0]  on_vel;
  logic [3:0]  channel;
  logic [7:0]  press_code;
  midi_event_t note_events_q [$];
  midi_event_t item_events [$];
  int          events_seen;

  function automatic int major_step(int s);
    case (s)
      0:       return 0;
      1:       return 2;
      2:       return 4;
      3:       return 5;
      4:       return 7;
      default: return 9;
    endcase
  endfunction

  function automatic logic [6:0] clamp_note(int n);
    return (n > int'(NOTE_MAX)) ? NOTE_MAX[6:0] : 7'(n);
  endfunction

  function automatic logic [6:0] matrix_note(int idx);
    return clamp_note(int'(base_note) + 12 * (idx / NUM_COLS) + major_step(idx % NUM_COLS));
  endfunction

  function automatic logic [6:0] remote_note(int n);
    if (n < NUM_LOCAL) return matrix_note(n);
    return clamp_note(int'(base_note) + 36 + major_step(3 + (n - NUM_LOCAL) % 3));
  endfunction

  task automatic add_event(logic down, logic [6:0] note, int key, logic [2:0] col);
    midi_event_t ev;
    ev.f.cable    = down ? CIN_NOTE_ON : CIN_NOTE_OFF;
    ev.f.status   = {down ? STATUS_NOTE_ON : STATUS_NOTE_OFF, channel};
    ev.f.note     = note;
    ev.f.velocity = down ? on_vel : 7'd0;
    ev.f.key      = 6'(key);
    ev.f.col      = col;
    ev.last       = 1'b0;
    item_events.push_back(ev);
  endtask

  // Mark the final event of the item and move the batch to the expected queue
  task automatic commit_events();
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    while (item_events.size() > 0) note_events_q.push_back(item_events.pop_front());
  endtask

  task automatic predict_scan(logic [3:0] levels);
    int   idx;
    logic down;
    for (int r = 0; r < 4; r++) begin
      idx = r * NUM_COLS + int'(scan_col);
      if (idx < NUM_LOCAL) begin
        down = !levels[r];
        if (key_down[idx] != down) begin
          key_down[idx] = down;
          add_event(down, matrix_note(idx), idx, scan_col);
        end
      end
    end
    scan_col = (int'(scan_col) == NUM_COLS - 1) ? 3'd0 : scan_col + 3'd1;
    commit_events();
  endtask

  task automatic predict_remote(logic [4:0] n, logic [7:0] key_byte);
    int   key;
    logic down;
    if (int'(n) < NUM_REMOTE) begin
      key  = NUM_LOCAL + int'(n);
      down = (key_byte == press_code);
      if (key_down[key] != down) begin
        key_down[key] = down;
        add_event(down, remote_note(int'(n)), key, 3'd0);
      end
    end
    commit_events();
  endtask

  task automatic check_event();
    midi_event_t exp_ev;
    kmm_result_t got;
    logic        bad;
    got = kmm_result_t'(out_tdata[$bits(kmm_result_t)-1:0]);
    events_seen++;
    if (note_events_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("event %0d unexpected: tdata=%h tuser=%b tlast=%b",
                 events_seen, out_tdata, out_tuser, out_tlast);
      return;
    end
    exp_ev = note_events_q.pop_front();
    bad = (out_tuser !== 1'b1) ||
          (got.cable !== exp_ev.f.cable) || (got.status !== exp_ev.f.status) ||
          (got.note !== exp_ev.f.note) || (got.velocity !== exp_ev.f.velocity) ||
          (got.key !== exp_ev.f.key) || (got.col !== exp_ev.f.col) ||
          (out_tlast !== exp_ev.last);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("event %0d exp: valid 1 cin %h status %h note %0d vel %0d key %0d col %0d last %b",
                 events_seen, exp_ev.f.cable, exp_ev.f.status, exp_ev.f.note,
                 exp_ev.f.velocity, exp_ev.f.key, exp_ev.f.col, exp_ev.last);
        $display("event %0d got: valid %b cin %h status %h note %0d vel %0d key %0d col %0d last %b",
                 events_seen, out_tuser, got.cable, got.status, got.note,
                 got.velocity, got.key, got.col, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) key_down[k] = 1'b0;
      scan_col    = 3'd0;
      base_note   = BASE_NOTE_RST;
      on_vel      = ON_VELOCITY_RST;
      channel     = MIDI_CHANNEL_RST;
      press_code  = PRESSED_CODE_RST;
      fail_count  = 0;
      events_seen = 0;
      note_events_q.delete();
      item_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BASE_NOTE:    base_note  = cfg_wdata[6:0];
          REG_ON_VELOCITY:  on_vel     = cfg_wdata[6:0];
          REG_MIDI_CHANNEL: channel    = cfg_wdata[3:0];
          REG_PRESSED_CODE: press_code = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_SCAN) predict_scan(in_tdata[3:0]);
        else predict_remote(in_tdata[8:4], in_tdata[16:9]);
      end
      if (out_tvalid && out_tready) check_event();
    end
    pending = note_events_q.size();
  end

endmodule

@@ tb/sv/key_matrix_to_midi_events_tb.sv @@
module key_matrix_to_midi_events_tb;
  import kmm_pkg::*;

  // Generous bound: every item at four events, each event waiting out a slow
  // receiver, plus the sender's gaps, the long hold-off and the idle waits.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Margin for an item with no event to clear the merge stage
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 33;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = CMD_SCAN;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = REG_BASE_NOTE;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int         fail_count;
  int         pending;
  int         cycle_count   = 0;
  // Long receiver hold-off: the sender raises a request, the receiver serves it
  int         hold_requests = 0;
  int         holds_served  = 0;
  int         hold_left     = 0;
  int         rx_phase      = 0;
  int         burst_left    = 0;
  // Pressed code currently in the block, so remote items can hit it often
  logic [7:0] cur_press_code = PRESSED_CODE_RST;

  key_matrix_to_midi_events u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Watch both channels and the register port, predict and compare
  kmm_event_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: serve a long hold-off when asked, otherwise rotate through
  // stall patterns of its own, one of them never stalling.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      hold_left    = HOLD_OFF_CYCLES - 1;
      out_tready   <= 1'b0;
    end else begin
      case ((rx_phase / 97) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_phase % 5 != 0);
      endcase
    end
  end

  // Sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one request and hold it until the block takes it
  task automatic send_request(logic cmd, logic [3:0] levels, logic [4:0] idx,
                              logic [7:0] key_byte);
    pace_sender();
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, key_byte, idx, levels};
    do @(posedge clk); while (!in_tready);
  endtask

  // Scan request; the remote fields carry noise the block must ignore
  task automatic send_scan(logic [3:0] levels);
    send_request(CMD_SCAN, levels, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endtask

  // Remote request; the row field carries noise
  task automatic send_remote(logic [4:0] idx, logic [7:0] key_byte);
    send_request(CMD_REMOTE, 4'($urandom_range(0, 15)), idx, key_byte);
  endtask

  // Drop valid and hold until every predicted event has arrived, then let
  // any item with no event leave the pipeline.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back while idle
  task automatic load_registers(logic [6:0] base, logic [6:0] vel, logic [3:0] chan,
                                logic [7:0] code);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BASE_NOTE;
    cfg_wdata <= {1'b0, base};
    @(posedge clk);
    cfg_addr  <= REG_ON_VELOCITY;
    cfg_wdata <= {1'b0, vel};
    @(posedge clk);
    cfg_addr  <= REG_MIDI_CHANNEL;
    cfg_wdata <= {4'd0, chan};
    @(posedge clk);
    cfg_addr  <= REG_PRESSED_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_press_code = code;
  endtask

  // One random request; counts tells whether the block acts on it at all
  task automatic send_random(output bit counts);
    int pick;
    pick   = $urandom_range(0, 99);
    counts = 1'b1;
    if (pick < 55) begin
      send_scan(4'($urandom_range(0, 15)));
    end else if (pick < 90) begin
      send_remote(5'($urandom_range(0, 26)),
                  ($urandom_range(0, 1) == 0) ? cur_press_code : 8'($urandom_range(0, 255)));
    end else begin
      // out-of-range remote index: noise only
      send_remote(5'($urandom_range(27, 31)), 8'($urandom_range(0, 255)));
      counts = 1'b0;
    end
  endtask

  task automatic run_phase(int n_items, bit with_hold);
    int done;
    bit counts;
    done = 0;
    while (done < n_items) begin
      // ask for the long receiver hold-off and keep offering through it
      if (with_hold && done == 10) hold_requests++;
      send_random(counts);
      if (counts) done++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Press every key of the matrix, column by column: four events each
    repeat (6) send_scan(4'b0000);
    // Column wraps to 0 with nothing changed: no event
    send_scan(4'b0000);
    // Release them all, starting from column 1
    repeat (6) send_scan(4'b1111);
    // Remote keys in the matrix layout and the thumb keys
    send_remote(5'd0,  PRESSED_CODE_RST);
    send_remote(5'd23, PRESSED_CODE_RST);
    send_remote(5'd24, PRESSED_CODE_RST);
    send_remote(5'd25, PRESSED_CODE_RST);
    send_remote(5'd26, PRESSED_CODE_RST);
    // Already pressed: no event
    send_remote(5'd26, PRESSED_CODE_RST);
    // Indexes past the remote half: ignored
    send_remote(5'd31, PRESSED_CODE_RST);
    send_remote(5'd27, 8'hff);
    // Releases by any other byte value
    send_remote(5'd0,  8'h55);
    send_remote(5'd23, 8'h00);
    send_remote(5'd24, 8'hff);
    wait_idle();

    // Lowest settings; the long hold-off falls in this phase
    load_registers(7'd0, 7'd0, 4'd0, 8'h00);
    run_phase(PHASE_ITEMS, 1'b1);
    // Highest settings: notes clamp at the top
    load_registers(7'd127, 7'd127, 4'd15, 8'hff);
    run_phase(PHASE_ITEMS, 1'b0);
    load_registers(7'd60, 7'd64, 4'd9, 8'h55);
    run_phase(PHASE_ITEMS, 1'b0);
    load_registers(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    run_phase(PHASE_ITEMS, 1'b0);

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
